@@ hdl/ssdq_pkg.sv @@
// Shared types and codes for the size-sorted download queue.
package ssdq_pkg;

    typedef enum logic [2:0] {
        OP_CLEAR  = 3'd0,
        OP_FIRST  = 3'd1,
        OP_NEXT   = 3'd2,
        OP_INSERT = 3'd3,
        OP_MOVE   = 3'd4,
        OP_REMOVE = 3'd5
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_FETCH,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHU_RD,
        S_SHU_WR,
        S_PLACE,
        S_SHD_RD,
        S_SHD_WR,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_START,
        IDX_INC,
        IDX_DEC,
        IDX_COUNT
    } idx_op_t;

    typedef enum logic [1:0] {
        LO_HOLD,
        LO_IDX,
        LO_CURSOR
    } lo_op_t;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_DN,
        RD_UP
    } rd_sel_t;

    typedef enum logic {
        WR_SHIFT,
        WR_PLACE
    } wr_sel_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_CLEAR,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    typedef enum logic [1:0] {
        CUR_HOLD,
        CUR_CLEAR,
        CUR_NEXT
    } cur_op_t;

    typedef struct packed {
        logic [30:0] id;
        logic [31:0] size;
    } entry_t;

    typedef struct packed {
        logic    load_in;
        idx_op_t idx_op;
        lo_op_t  lo_op;
        logic    save_size;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        cnt_op_t cnt_op;
        cur_op_t cur_op;
        logic    set_valid;
        logic    set_found;
        logic    set_ovf;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic [2:0] func;
        logic       idx_lt_count;
        logic       idx_up_lt_count;
        logic       idx_eq_lo;
        logic       hit;
        logic       full;
        logic       out_free;
    } status_t;

endpackage

@@ hdl/ssdq_ctrl.sv @@
// Sequencing state machine for the size-sorted download queue.
module ssdq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ssdq_pkg::status_t stat,
    output ssdq_pkg::cmd_t    cmd
);
    import ssdq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (stat.func)
                    OP_FIRST, OP_NEXT: state_next = S_FETCH;
                    OP_INSERT:         state_next = stat.full ? S_DONE : S_SCAN_RD;
                    OP_MOVE, OP_REMOVE: state_next = S_SCAN_RD;
                    default:           state_next = S_DONE;
                endcase
            end
            S_FETCH: state_next = S_DONE;
            S_SCAN_RD: begin
                if (stat.idx_lt_count) begin
                    state_next = S_SCAN_CMP;
                end else if (stat.func == OP_INSERT) begin
                    state_next = S_SHU_RD;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_SCAN_CMP: begin
                if (stat.hit) begin
                    state_next = (stat.func == OP_REMOVE) ? S_SHD_RD : S_SHU_RD;
                end else begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SHU_RD: state_next = stat.idx_eq_lo ? S_PLACE : S_SHU_WR;
            S_SHU_WR: state_next = S_SHU_RD;
            S_PLACE:  state_next = S_DONE;
            S_SHD_RD: state_next = stat.idx_up_lt_count ? S_SHD_WR : S_DONE;
            S_SHD_WR: state_next = S_SHD_RD;
            S_DONE: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready       = 1'b0;
        cmd           = '0;
        cmd.idx_op    = IDX_HOLD;
        cmd.lo_op     = LO_HOLD;
        cmd.rd_sel    = RD_IDX;
        cmd.wr_sel    = WR_SHIFT;
        cmd.cnt_op    = CNT_HOLD;
        cmd.cur_op    = CUR_HOLD;
        case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            S_DECODE: begin
                cmd.idx_op = IDX_START;
                if (stat.func == OP_CLEAR) begin
                    cmd.cnt_op = CNT_CLEAR;
                    cmd.cur_op = CUR_CLEAR;
                end
                if (stat.func == OP_INSERT && stat.full) begin
                    cmd.set_ovf = 1'b1;
                end
            end
            S_FETCH: begin
                if (stat.idx_lt_count) begin
                    cmd.rd_en     = 1'b1;
                    cmd.set_valid = 1'b1;
                    cmd.cur_op    = CUR_NEXT;
                end
            end
            S_SCAN_RD: begin
                if (stat.idx_lt_count) begin
                    cmd.rd_en = 1'b1;
                end else if (stat.func == OP_INSERT) begin
                    // No larger entry: the new one goes at the end.
                    cmd.lo_op  = LO_IDX;
                    cmd.idx_op = IDX_COUNT;
                end
            end
            S_SCAN_CMP: begin
                if (stat.hit) begin
                    if (stat.func == OP_INSERT) begin
                        cmd.lo_op  = LO_IDX;
                        cmd.idx_op = IDX_COUNT;
                    end else begin
                        cmd.set_found = 1'b1;
                        if (stat.func == OP_MOVE) begin
                            cmd.lo_op     = LO_CURSOR;
                            cmd.save_size = 1'b1;
                        end
                    end
                end else begin
                    cmd.idx_op = IDX_INC;
                end
            end
            S_SHU_RD: begin
                if (!stat.idx_eq_lo) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_DN;
                end
            end
            S_SHU_WR: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_SHIFT;
                cmd.idx_op = IDX_DEC;
            end
            S_PLACE: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_PLACE;
                if (stat.func == OP_INSERT) begin
                    cmd.cnt_op = CNT_INC;
                end
            end
            S_SHD_RD: begin
                if (stat.idx_up_lt_count) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_UP;
                end else begin
                    cmd.cnt_op = CNT_DEC;
                end
            end
            S_SHD_WR: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_SHIFT;
                cmd.idx_op = IDX_INC;
            end
            S_DONE: begin
                cmd.out_load = stat.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ hdl/ssdq_datapath.sv @@
// Entry memory, index registers and result register of the download queue.
module ssdq_datapath #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [2:0]                           s_func,
    input  logic [30:0]                          s_server_id,
    input  logic [31:0]                          s_entry_size,
    input  ssdq_pkg::cmd_t                       cmd,
    output ssdq_pkg::status_t                    stat,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_entry_valid,
    output logic [30:0]                          m_entry_id,
    output logic                                 m_found,
    output logic                                 m_overflow,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]     m_entry_count
);
    import ssdq_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    entry_t mem [QUEUE_DEPTH];
    entry_t rd_q;

    logic [2:0]    func_reg;
    logic [30:0]   id_reg;
    logic [31:0]   size_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] lo_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] cursor_reg;
    logic          valid_flag_reg;
    logic          found_flag_reg;
    logic          ovf_flag_reg;

    logic [CW:0]   idx_up;
    logic [CW-1:0] idx_dn;
    logic [CW-1:0] rd_idx;
    logic [CW-1:0] wr_idx;
    entry_t        wr_data;

    assign idx_up = {1'b0, idx_reg} + (CW+1)'(1);
    assign idx_dn = idx_reg - CW'(1);

    always_comb begin
        case (cmd.rd_sel)
            RD_DN:   rd_idx = idx_dn;
            RD_UP:   rd_idx = idx_up[CW-1:0];
            default: rd_idx = idx_reg;
        endcase
    end

    assign wr_idx  = (cmd.wr_sel == WR_PLACE) ? lo_reg : idx_reg;
    assign wr_data = (cmd.wr_sel == WR_PLACE) ? entry_t'{id: id_reg, size: size_reg} : rd_q;

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[wr_idx[AW-1:0]] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_q <= mem[rd_idx[AW-1:0]];
        end
    end

    // Item fields and per-item result flags.
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            func_reg       <= s_func;
            id_reg         <= s_server_id;
            size_reg       <= s_entry_size;
            valid_flag_reg <= 1'b0;
            found_flag_reg <= 1'b0;
            ovf_flag_reg   <= 1'b0;
        end else begin
            if (cmd.save_size) begin
                size_reg <= rd_q.size;
            end
            if (cmd.set_valid) begin
                valid_flag_reg <= 1'b1;
            end
            if (cmd.set_found) begin
                found_flag_reg <= 1'b1;
            end
            if (cmd.set_ovf) begin
                ovf_flag_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.idx_op)
            IDX_START: begin
                if (func_reg == OP_INSERT || func_reg == OP_FIRST) begin
                    idx_reg <= '0;
                end else begin
                    idx_reg <= cursor_reg;
                end
            end
            IDX_INC:   idx_reg <= idx_up[CW-1:0];
            IDX_DEC:   idx_reg <= idx_dn;
            IDX_COUNT: idx_reg <= count_reg;
            default:   idx_reg <= idx_reg;
        endcase
        case (cmd.lo_op)
            LO_IDX:    lo_reg <= idx_reg;
            LO_CURSOR: lo_reg <= cursor_reg;
            default:   lo_reg <= lo_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            cursor_reg <= '0;
        end else begin
            case (cmd.cnt_op)
                CNT_CLEAR: count_reg <= '0;
                CNT_INC:   count_reg <= count_reg + CW'(1);
                CNT_DEC:   count_reg <= count_reg - CW'(1);
                default:   count_reg <= count_reg;
            endcase
            case (cmd.cur_op)
                CUR_CLEAR: cursor_reg <= '0;
                CUR_NEXT:  cursor_reg <= idx_up[CW-1:0];
                default:   cursor_reg <= cursor_reg;
            endcase
        end
    end

    // Result register: a finished item waits here while the next one is taken in.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_entry_valid <= valid_flag_reg;
            m_entry_id    <= valid_flag_reg ? rd_q.id : '0;
            m_found       <= found_flag_reg;
            m_overflow    <= ovf_flag_reg;
            m_entry_count <= count_reg;
        end
    end

    always_comb begin
        stat.func            = func_reg;
        stat.idx_lt_count    = idx_reg < count_reg;
        stat.idx_up_lt_count = idx_up < {1'b0, count_reg};
        stat.idx_eq_lo       = idx_reg == lo_reg;
        stat.hit             = (func_reg == OP_INSERT) ? (size_reg < rd_q.size)
                                                       : (rd_q.id == id_reg);
        stat.full            = count_reg == CW'(QUEUE_DEPTH);
        stat.out_free        = !m_valid || m_ready;
    end

endmodule

@@ hdl/size_sorted_download_queue.sv @@
// Top level of the size-sorted download queue.
// The s_ channel carries one command item: s_func selects clear, first, next,
// sorted insert, move to cursor or remove; s_server_id and s_entry_size are
// its operands. Every item returns exactly one result item on the m_ channel:
// m_entry_valid and m_entry_id for first/next, m_found for move and remove,
// m_overflow for an insert into a full queue, and m_entry_count after the item.
// Items are handled one at a time. Insert, move and remove walk the entry
// memory one entry at a time, first to search and then to shift entries. A
// new item is taken while the previous result still waits in the output
// register; if the receiver stalls, the block holds the next finished result
// and stops accepting until the register frees.
// Reset empties the queue and zeroes the cursor at once; the entry memory is
// not cleared, since only positions below the entry count are ever read.
module size_sorted_download_queue #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [2:0]                        s_func,
    input  logic [30:0]                       s_server_id,
    input  logic [31:0]                       s_entry_size,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_entry_valid,
    output logic [30:0]                       m_entry_id,
    output logic                              m_found,
    output logic                              m_overflow,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]  m_entry_count
);
    import ssdq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t    cmd;
    status_t stat;

    ssdq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ssdq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_func        (s_func),
        .s_server_id   (s_server_id),
        .s_entry_size  (s_entry_size),
        .cmd           (cmd),
        .stat          (stat),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_entry_valid (m_entry_valid),
        .m_entry_id    (m_entry_id),
        .m_found       (m_found),
        .m_overflow    (m_overflow),
        .m_entry_count (m_entry_count)
    );

`ifndef SYNTH
    // The memory is only written while an item is in progress.
    a_no_write_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_en |-> !s_ready)
        else $error("entry memory written while idle");

    // A dropped insert is only reported when the queue is full.
    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_overflow) |-> (m_entry_count == CW'(QUEUE_DEPTH)))
        else $error("overflow reported on a queue that is not full");

    // A returned entry and a search hit come from different commands.
    a_valid_found_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_found && m_entry_valid))
        else $error("entry_valid and found both set");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid)
        else $error("result loaded but not presented");
`endif

endmodule

@@ tb/sv/size_sorted_download_queue_tb.sv @@
// Self-checking testbench for the size-sorted download queue.
module size_sorted_download_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ssdq_pkg::*;

    localparam int QUEUE_DEPTH = 64;
    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam int unsigned SETTLE_CYCLES = 300;
    localparam logic [2:0] FUNC_RSVD_A = 3'd6;
    localparam logic [2:0] FUNC_RSVD_B = 3'd7;

    typedef struct packed {
        logic        entry_valid;
        logic [30:0] entry_id;
        logic        found;
        logic        overflow;
        logic [6:0]  entry_count;
    } queue_reply_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_func = OP_CLEAR;
    logic [30:0] s_server_id = '0;
    logic [31:0] s_entry_size = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_entry_valid;
    logic [30:0] m_entry_id;
    logic        m_found;
    logic        m_overflow;
    logic [6:0]  m_entry_count;

    // Shadow copy of the queue contents, updated when an item is accepted.
    logic [30:0] shadow_ids [QUEUE_DEPTH];
    logic [31:0] shadow_sizes [QUEUE_DEPTH];
    int          shadow_count = 0;
    int          shadow_cursor = 0;

    queue_reply_t pending_replies[$];
    int unsigned  mismatch_count = 0;
    int unsigned  cycle_count = 0;
    int unsigned  send_idle_pct = 0;
    int unsigned  recv_stall_pct = 0;
    int unsigned  hold_cycles = 0;
    logic         receiver_hold = 1'b0;
    event         hold_start;

    size_sorted_download_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_server_id   (s_server_id),
        .s_entry_size  (s_entry_size),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_entry_valid (m_entry_valid),
        .m_entry_id    (m_entry_id),
        .m_found       (m_found),
        .m_overflow    (m_overflow),
        .m_entry_count (m_entry_count)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("size_sorted_download_queue_tb: errors");
            $finish;
        end
    end

    // Applies one operation to the shadow queue and returns the reply it must produce.
    function automatic queue_reply_t predict_queue_op(input logic [2:0] fn,
                                                      input logic [30:0] id,
                                                      input logic [31:0] sz);
        queue_reply_t reply;
        int           hit;
        int           slot;
        int           p;
        logic [30:0]  moved_id;
        logic [31:0]  moved_size;
        reply = '0;
        hit = -1;
        if (fn == OP_MOVE || fn == OP_REMOVE) begin
            for (p = shadow_cursor; p < shadow_count; p++) begin
                if (shadow_ids[p] == id) begin
                    hit = p;
                    break;
                end
            end
        end
        case (fn)
            OP_CLEAR: begin
                shadow_count = 0;
                shadow_cursor = 0;
            end
            OP_FIRST: begin
                if (shadow_count > 0) begin
                    reply.entry_valid = 1'b1;
                    reply.entry_id = shadow_ids[0];
                    shadow_cursor = 1;
                end
            end
            OP_NEXT: begin
                if (shadow_cursor < shadow_count) begin
                    reply.entry_valid = 1'b1;
                    reply.entry_id = shadow_ids[shadow_cursor];
                    shadow_cursor++;
                end
            end
            OP_INSERT: begin
                if (shadow_count >= QUEUE_DEPTH) begin
                    reply.overflow = 1'b1;
                end else begin
                    // Equal sizes stay in arrival order: stop only at a strictly larger one.
                    slot = shadow_count;
                    for (p = 0; p < shadow_count; p++) begin
                        if (sz < shadow_sizes[p]) begin
                            slot = p;
                            break;
                        end
                    end
                    for (p = shadow_count; p > slot; p--) begin
                        shadow_ids[p] = shadow_ids[p - 1];
                        shadow_sizes[p] = shadow_sizes[p - 1];
                    end
                    shadow_ids[slot] = id;
                    shadow_sizes[slot] = sz;
                    shadow_count++;
                end
            end
            OP_MOVE: begin
                if (hit >= 0) begin
                    moved_id = shadow_ids[hit];
                    moved_size = shadow_sizes[hit];
                    for (p = hit; p > shadow_cursor; p--) begin
                        shadow_ids[p] = shadow_ids[p - 1];
                        shadow_sizes[p] = shadow_sizes[p - 1];
                    end
                    shadow_ids[shadow_cursor] = moved_id;
                    shadow_sizes[shadow_cursor] = moved_size;
                    reply.found = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (hit >= 0) begin
                    for (p = hit; p + 1 < shadow_count; p++) begin
                        shadow_ids[p] = shadow_ids[p + 1];
                        shadow_sizes[p] = shadow_sizes[p + 1];
                    end
                    shadow_count--;
                    reply.found = 1'b1;
                end
            end
            default: begin
            end
        endcase
        reply.entry_count = shadow_count[6:0];
        return reply;
    endfunction

    // Mostly picks an id that is held, preferring positions at or past the cursor when near_cursor is set.
    function automatic logic [30:0] pick_id(input bit near_cursor);
        logic [30:0] id;
        id = 31'($urandom);
        if (shadow_count > 0 && $urandom_range(99) >= 20) begin
            if (near_cursor && shadow_cursor < shadow_count && $urandom_range(3) != 0)
                id = shadow_ids[$urandom_range(shadow_count - 1, shadow_cursor)];
            else
                id = shadow_ids[$urandom_range(shadow_count - 1)];
        end
        return id;
    endfunction

    function automatic logic [31:0] pick_size();
        logic [31:0] sz;
        case ($urandom_range(3))
            0: sz = $urandom_range(15);
            1: sz = $urandom;
            2: sz = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
            default: begin
                // Copy a held size so that ties are common.
                if (shadow_count > 0)
                    sz = shadow_sizes[$urandom_range(shadow_count - 1)];
                else
                    sz = $urandom;
            end
        endcase
        return sz;
    endfunction

    task automatic send_item(input logic [2:0] fn, input logic [30:0] id, input logic [31:0] sz);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_func <= fn;
        s_server_id <= id;
        s_entry_size <= sz;
        do @(posedge aclk); while (!s_ready);
        pending_replies.push_back(predict_queue_op(fn, id, sz));
    endtask

    task automatic send_random_op();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 45)
            send_item(OP_INSERT,
                      ($urandom_range(99) < 15) ? pick_id(1'b0) : 31'($urandom),
                      pick_size());
        else if (pick < 60)
            send_item(OP_NEXT, 31'($urandom), $urandom);
        else if (pick < 65)
            send_item(OP_FIRST, 31'($urandom), $urandom);
        else if (pick < 80)
            send_item(OP_MOVE, pick_id(1'b1), $urandom);
        else if (pick < 96)
            send_item(OP_REMOVE, pick_id(1'b1), $urandom);
        else if (pick < 98)
            send_item(OP_CLEAR, 31'($urandom), $urandom);
        else
            send_item($urandom_range(1) ? FUNC_RSVD_A : FUNC_RSVD_B, 31'($urandom), $urandom);
    endtask

    task automatic wait_for_replies();
        s_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
    endtask

    task automatic test_empty_queue();
        send_item(OP_FIRST, 31'd1, 32'd0);
        send_item(OP_NEXT, 31'd1, 32'd0);
        send_item(OP_MOVE, 31'd5, 32'd0);
        send_item(OP_REMOVE, 31'd5, 32'd0);
        send_item(FUNC_RSVD_A, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_item(FUNC_RSVD_B, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_sorted_order();
        send_item(OP_INSERT, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_INSERT, 31'd0, 32'd0);
        send_item(OP_INSERT, 31'd1, 32'd100);
        send_item(OP_INSERT, 31'd2, 32'd100);
        send_item(OP_INSERT, 31'd3, 32'd50);
        send_item(OP_FIRST, 31'd0, 32'd0);
        send_item(OP_NEXT, 31'd0, 32'd0);
        // This entry lands behind the cursor, which must not move.
        send_item(OP_INSERT, 31'd4, 32'd10);
        send_item(OP_MOVE, 31'd0, 32'd0);
        send_item(OP_MOVE, 31'h7FFF_FFFF, 32'd0);
        send_item(OP_REMOVE, 31'd1, 32'd0);
        send_item(OP_REMOVE, 31'd4, 32'd0);
        repeat (4) send_item(OP_NEXT, 31'd0, 32'd0);
        send_item(OP_MOVE, 31'd2, 32'd0);
        send_item(OP_REMOVE, 31'd2, 32'd0);
        send_item(OP_CLEAR, 31'd0, 32'd0);
        send_item(OP_NEXT, 31'd0, 32'd0);
        send_item(OP_INSERT, 31'd9, 32'd5);
        send_item(OP_MOVE, 31'd9, 32'd0);
        wait_for_replies();
    endtask

    task automatic test_fill_and_overflow();
        send_item(OP_CLEAR, 31'($urandom), $urandom);
        while (shadow_count < QUEUE_DEPTH) send_item(OP_INSERT, 31'($urandom), pick_size());
        send_item(OP_INSERT, 31'($urandom), pick_size());
        send_item(OP_FIRST, 31'($urandom), $urandom);
        send_item(OP_REMOVE, pick_id(1'b1), $urandom);
        send_item(OP_INSERT, 31'($urandom), pick_size());
        send_item(OP_INSERT, 31'($urandom), pick_size());
        wait_for_replies();
    endtask

    task automatic test_receiver_holdoff();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 400;
        -> hold_start;
        repeat (12) send_random_op();
        wait_for_replies();
    endtask

    task automatic test_random_traffic(input int unsigned items, input int unsigned send_idle,
                                       input int unsigned recv_stall);
        send_idle_pct = send_idle;
        recv_stall_pct = recv_stall;
        repeat (items) send_random_op();
        wait_for_replies();
    endtask

    always begin
        @(hold_start);
        receiver_hold <= 1'b1;
        repeat (hold_cycles) @(posedge aclk);
        receiver_hold <= 1'b0;
    end

    task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        queue_reply_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !receiver_hold && ($urandom_range(99) >= recv_stall_pct);
            if (m_valid && m_ready) begin
                if (pending_replies.size() == 0) begin
                    $display("%0t: result item with none expected, entry_count 0x%0h",
                             $time, m_entry_count);
                    mismatch_count++;
                end else begin
                    want = pending_replies.pop_front();
                    check_field("entry_valid", 32'(want.entry_valid), 32'(m_entry_valid));
                    check_field("entry_id", 32'(want.entry_id), 32'(m_entry_id));
                    check_field("found", 32'(want.found), 32'(m_found));
                    check_field("overflow", 32'(want.overflow), 32'(m_overflow));
                    check_field("entry_count", 32'(want.entry_count), 32'(m_entry_count));
                end
            end
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_queue();
        test_sorted_order();
        test_fill_and_overflow();
        test_receiver_holdoff();
        test_random_traffic(330, 0, 0);
        test_random_traffic(330, 78, 0);
        test_random_traffic(330, 0, 78);
        test_random_traffic(330, 37, 37);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("size_sorted_download_queue_tb: clean");
        else
            $display("size_sorted_download_queue_tb: errors");
        $finish;
    end

endmodule
